// ===== rtl/bdq_pkg.sv =====
// Shared constants, operation and status codes, and the result word type
// for the bounded deque. No dependencies.
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int FILL_W   = 5;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [FILL_W-1:0]   fill_count;
    } res_t;

endpackage

// ===== rtl/bdq_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on bdq_pkg.
interface bdq_req_if;
    import bdq_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface bdq_rsp_if;
    import bdq_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [FILL_W-1:0]   fill_count;

    modport source (output valid, output status, output position, output fill_count,
                    input ready);
    modport sink   (input valid, input status, input position, input fill_count,
                    output ready);
endinterface

// ===== rtl/bounded_deque_with_search.sv =====
// Bounded deque of signed 32-bit words with remove and find by value.
// Push back, pop back and any word that neither scans nor moves entries go from execute
// straight to the result; pop front and push front move entries, find scans, and remove
// scans and then closes the gap, one compare or one entry move per cycle.
// One word in flight; the next is taken in the cycle after the response loads.
// Reset clears the fill count; entries are not cleared.
module bounded_deque_with_search #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);
    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                      seq_idle;
    logic                      res_valid;
    logic                      res_ack;
    res_t                      res;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic signed [VALUE_W-1:0] mem_wdata;
    logic                      mem_re;
    logic [AW-1:0]             mem_raddr;
    logic signed [VALUE_W-1:0] mem_rdata;
    logic                      out_valid_reg, out_valid_next;
    res_t                      out_res_reg;

    assign req.ready = seq_idle;
    assign res_ack   = !out_valid_reg || rsp.ready;

    bdq_seq #(.DEPTH(DEPTH)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req.valid && req.ready),
        .op        (req.op),
        .value     (req.value),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_ack   (res_ack),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bdq_store #(.DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ack)
        begin
            out_res_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_res_reg.status;
    assign rsp.position   = out_res_reg.position;
    assign rsp.fill_count = out_res_reg.fill_count;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while sequencer busy");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ack) |=> (rsp.valid && rsp.status == $past(res.status)))
        else $error("result word not loaded into output register");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_FULL) |-> (res.fill_count == FILL_W'(DEPTH)))
        else $error("full status with store not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_EMPTY) |-> (res.fill_count == '0))
        else $error("empty status with entries stored");

endmodule

// ===== rtl/bdq_store.sv =====
// Entry memory: one write port and one read port with registered read data.
// Depends on bdq_pkg.
module bdq_store #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH)-1:0]          waddr,
    input  logic signed [bdq_pkg::VALUE_W-1:0] wdata,
    input  logic                              re,
    input  logic [$clog2(DEPTH)-1:0]          raddr,
    output logic signed [bdq_pkg::VALUE_W-1:0] rdata
);
    import bdq_pkg::*;

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bdq_seq.sv =====
// Sequencer for the deque: one comparator and one memory port pair, stepped
// over entries for search, gap closing and front insertion.
// Depends on bdq_pkg and drives bdq_store.
module bdq_seq #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [bdq_pkg::OP_W-1:0]           op,
    input  logic signed [bdq_pkg::VALUE_W-1:0] value,
    output logic                               idle,
    output logic                               res_valid,
    input  logic                               res_ack,
    output bdq_pkg::res_t                      res,
    output logic                               mem_we,
    output logic [$clog2(DEPTH)-1:0]           mem_waddr,
    output logic signed [bdq_pkg::VALUE_W-1:0] mem_wdata,
    output logic                               mem_re,
    output logic [$clog2(DEPTH)-1:0]           mem_raddr,
    input  logic signed [bdq_pkg::VALUE_W-1:0] mem_rdata
);
    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_DOWN   = 7'b0001000,
        S_UP     = 7'b0010000,
        S_HEAD   = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]           cmp_idx_reg, cmp_idx_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic                    match;
    logic [CW-1:0]           cmp_inc;

    assign match   = (mem_rdata == key_reg);
    assign cmp_inc = cmp_idx_reg + CW'(1);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        cmp_idx_next = cmp_idx_reg;
        status_next  = status_reg;
        pos_next     = pos_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = key_reg;
        mem_re       = 1'b0;
        mem_raddr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    key_next   = value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_DONE;
                pos_next    = '0;
                state_next  = S_FINISH;
                case (op_reg)
                    OP_PUSH_FRONT:
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            mem_re      = 1'b1;
                            mem_raddr   = AW'(count_reg - CW'(1));
                            wr_ptr_next = count_reg;
                            state_next  = S_UP;
                        end
                    end
                    OP_PUSH_BACK:
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_REMOVE, OP_FIND:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_MISSING;
                        end
                        else
                        begin
                            mem_re       = 1'b1;
                            rd_ptr_next  = CW'(1);
                            cmp_idx_next = '0;
                            state_next   = S_SCAN;
                        end
                    end
                    OP_POP_FRONT:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (count_reg == CW'(1))
                        begin
                            count_next = '0;
                        end
                        else
                        begin
                            mem_re      = 1'b1;
                            mem_raddr   = AW'(1);
                            wr_ptr_next = '0;
                            rd_ptr_next = CW'(2);
                            state_next  = S_DOWN;
                        end
                    end
                    OP_POP_BACK:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    default:
                    begin
                        status_next = ST_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (rd_ptr_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(rd_ptr_reg);
                end
                if (match)
                begin
                    pos_next = AW'(cmp_idx_reg);
                    if (op_reg == OP_FIND)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (cmp_inc >= count_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        wr_ptr_next = cmp_idx_reg;
                        rd_ptr_next = rd_ptr_reg + CW'(1);
                        state_next  = S_DOWN;
                    end
                end
                else if (cmp_inc >= count_reg)
                begin
                    status_next = ST_MISSING;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmp_idx_next = cmp_inc;
                    rd_ptr_next  = rd_ptr_reg + CW'(1);
                end
            end
            S_DOWN:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(wr_ptr_reg);
                mem_wdata = mem_rdata;
                if (rd_ptr_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(rd_ptr_reg);
                end
                if (rd_ptr_reg >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FINISH;
                end
                else
                begin
                    wr_ptr_next = wr_ptr_reg + CW'(1);
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                end
            end
            S_UP:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(wr_ptr_reg);
                mem_wdata = mem_rdata;
                if (wr_ptr_reg == CW'(1))
                begin
                    state_next = S_HEAD;
                end
                else
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = AW'(wr_ptr_reg - CW'(2));
                    wr_ptr_next = wr_ptr_reg - CW'(1);
                end
            end
            S_HEAD:
            begin
                mem_we     = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        rd_ptr_reg  <= rd_ptr_next;
        wr_ptr_reg  <= wr_ptr_next;
        cmp_idx_reg <= cmp_idx_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
    end

    assign idle           = (state_reg == S_IDLE);
    assign res_valid      = (state_reg == S_FINISH);
    assign res.status     = status_reg;
    assign res.position   = POS_W'(pos_reg);
    assign res.fill_count = FILL_W'(count_reg);

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for bounded_deque_with_search: directed table, then random words,
// scored against typed table rows or a queue-based deque predictor. Depends on bdq_pkg, bdq_req_if, bdq_rsp_if.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bdq_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int RANDOM_WORDS = 680;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef logic signed [VALUE_W-1:0] word_t;

    typedef struct {
        logic [OP_W-1:0] op;
        word_t           value;
        int              reps;
        bit              typed;
        res_t            want;
    } row_t;

    logic clk;
    logic rst_n;

    bdq_req_if req_ch();
    bdq_rsp_if rsp_ch();

    bounded_deque_with_search #(.DEPTH(DEPTH)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    word_t deque_model[$];
    res_t  pending_results[$];
    row_t  directed_rows[$];
    word_t key_pool[6];
    int    src_idle_pct = 15;
    int    snk_idle_pct = 87;
    int    mismatches   = 0;
    int    idle_cycles  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one word to the predicted deque and return the result it should give.
    task automatic deque_step(input logic [OP_W-1:0] op, input word_t value, output res_t r);
        int hit;
        word_t dropped;
        hit = -1;
        r = '0;
        r.status = ST_DONE;
        case (op)
            OP_PUSH_FRONT:
                if (deque_model.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                    deque_model.push_front(value);
            OP_PUSH_BACK:
                if (deque_model.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                    deque_model.push_back(value);
            OP_REMOVE, OP_FIND:
            begin
                foreach (deque_model[i])
                    if (hit < 0 && deque_model[i] == value)
                        hit = i;
                if (hit < 0)
                    r.status = ST_MISSING;
                else
                begin
                    r.position = hit[POS_W-1:0];
                    if (op == OP_REMOVE)
                        deque_model.delete(hit);
                end
            end
            OP_POP_FRONT:
                if (deque_model.size() == 0)
                    r.status = ST_EMPTY;
                else
                    dropped = deque_model.pop_front();
            OP_POP_BACK:
                if (deque_model.size() == 0)
                    r.status = ST_EMPTY;
                else
                    dropped = deque_model.pop_back();
            default: ;
        endcase
        r.fill_count = FILL_W'(deque_model.size());
    endtask

    task automatic send_word(input logic [OP_W-1:0] op, input word_t value,
                             input bit typed, input res_t want);
        res_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        deque_step(op, value, predicted);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input word_t value, input int reps,
                           input bit typed, input logic [STATUS_W-1:0] st,
                           input int pos, input int fill);
        row_t row;
        row.op                = op;
        row.value             = value;
        row.reps              = reps;
        row.typed             = typed;
        row.want.status       = st;
        row.want.position     = pos[POS_W-1:0];
        row.want.fill_count   = fill[FILL_W-1:0];
        directed_rows.push_back(row);
    endtask

    always @(negedge clk)
        rsp_ch.ready <= rst_n && ($urandom_range(0, 99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: status %0d position %0d fill %0d",
                             rsp_ch.status, rsp_ch.position, rsp_ch.fill_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.position !== want.position ||
                    rsp_ch.fill_count !== want.fill_count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("bad word: status %0d/%0d position %0d/%0d fill %0d/%0d",
                                 rsp_ch.status, want.status, rsp_ch.position, want.position,
                                 rsp_ch.fill_count, want.fill_count);
                end
            end
        end
    end

    always @(posedge clk)
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        res_t            none;
        logic [OP_W-1:0] op;
        word_t           value;
        bit              filling;
        int              roll;
        int              push_share;
        int              pop_share;
        int              n;

        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_PUSH_FRONT;
        req_ch.value = '0;
        none         = '0;
        filling      = 1'b1;

        key_pool[0] = 32'sd0;
        key_pool[1] = -32'sd1;
        key_pool[2] = word_t'(32'h8000_0000);
        key_pool[3] = word_t'(32'h7FFF_FFFF);
        key_pool[4] = word_t'(32'h1234_5678);
        key_pool[5] = 32'sd7;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_row(OP_POP_FRONT,  32'sd0,                       1, 1, ST_EMPTY,   0,  0);
        add_row(OP_POP_BACK,   32'sd0,                       1, 1, ST_EMPTY,   0,  0);
        add_row(OP_FIND,       32'sd0,                       1, 1, ST_MISSING, 0,  0);
        add_row(OP_REMOVE,     32'sd0,                       1, 1, ST_MISSING, 0,  0);
        add_row(OP_SPARE_6,    -32'sd1,                      1, 1, ST_DONE,    0,  0);
        add_row(OP_SPARE_7,    -32'sd1,                      1, 1, ST_DONE,    0,  0);
        add_row(OP_PUSH_BACK,  word_t'(32'h7FFF_FFFF),       1, 1, ST_DONE,    0,  1);
        add_row(OP_POP_BACK,   32'sd0,                       1, 1, ST_DONE,    0,  0);
        add_row(OP_PUSH_FRONT, word_t'(32'h8000_0000),       1, 1, ST_DONE,    0,  1);
        add_row(OP_PUSH_BACK,  -32'sd1,                      1, 1, ST_DONE,    0,  2);
        add_row(OP_PUSH_FRONT, 32'sd0,                       1, 1, ST_DONE,    0,  3);
        add_row(OP_FIND,       -32'sd1,                      1, 1, ST_DONE,    2,  3);
        add_row(OP_FIND,       32'sd5,                       1, 1, ST_MISSING, 0,  3);
        add_row(OP_REMOVE,     word_t'(32'h8000_0000),       1, 1, ST_DONE,    1,  2);
        add_row(OP_POP_FRONT,  32'sd0,                       1, 1, ST_DONE,    0,  1);
        add_row(OP_PUSH_BACK,  word_t'(32'h5555_5550),      15, 0, ST_DONE,    0,  0);
        add_row(OP_PUSH_FRONT, 32'sd1,                       1, 1, ST_FULL,    0, 16);
        add_row(OP_PUSH_BACK,  32'sd2,                       1, 1, ST_FULL,    0, 16);
        add_row(OP_FIND,       word_t'(32'h5555_5550),       1, 1, ST_DONE,    1, 16);
        add_row(OP_FIND,       word_t'(32'h5555_555E),       1, 1, ST_DONE,   15, 16);
        add_row(OP_REMOVE,     word_t'(32'h5555_555E),       1, 1, ST_DONE,   15, 15);
        add_row(OP_REMOVE,     -32'sd1,                      1, 1, ST_DONE,    0, 14);
        add_row(OP_SPARE_6,    32'sd0,                       1, 1, ST_DONE,    0, 14);
        add_row(OP_POP_FRONT,  32'sd0,                      14, 0, ST_DONE,    0,  0);
        add_row(OP_POP_FRONT,  32'sd0,                       1, 1, ST_EMPTY,   0,  0);
        add_row(OP_POP_BACK,   32'sd0,                       1, 1, ST_EMPTY,   0,  0);

        foreach (directed_rows[r])
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_word(directed_rows[r].op, directed_rows[r].value + k,
                          directed_rows[r].typed, directed_rows[r].want);

        n = 0;
        while (n < RANDOM_WORDS)
        begin
            if (n < RANDOM_WORDS / 3)
            begin
                src_idle_pct = 15;
                snk_idle_pct = 87;
            end
            else if (n < 2 * RANDOM_WORDS / 3)
            begin
                src_idle_pct = 87;
                snk_idle_pct = 15;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            if ($urandom_range(0, 39) == 0)
                filling = !filling;
            push_share = filling ? 30 : 10;
            pop_share  = filling ? 8 : 23;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = roll[0] ? OP_SPARE_7 : OP_SPARE_6;
            else if (roll < 3 + push_share)
                op = OP_PUSH_FRONT;
            else if (roll < 3 + 2 * push_share)
                op = OP_PUSH_BACK;
            else if (roll < 3 + 2 * push_share + pop_share)
                op = OP_POP_FRONT;
            else if (roll < 3 + 2 * push_share + 2 * pop_share)
                op = OP_POP_BACK;
            else if (roll[0])
                op = OP_REMOVE;
            else
                op = OP_FIND;

            // aim most keys at stored entries so lookups hit
            if ((op == OP_REMOVE || op == OP_FIND) && deque_model.size() > 0 &&
                $urandom_range(0, 3) != 0)
                value = deque_model[$urandom_range(0, deque_model.size() - 1)];
            else if ($urandom_range(0, 2) == 0)
                value = key_pool[$urandom_range(0, 5)];
            else
                value = $urandom;

            send_word(op, value, 1'b0, none);
            if (op != OP_SPARE_6 && op != OP_SPARE_7)
                n++;
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bdq_pkg.sv
rtl/bdq_if.sv
rtl/bdq_store.sv
rtl/bdq_seq.sv
rtl/bounded_deque_with_search.sv
tb/testbench.sv
